@@ sv/bfb_pkg.sv @@
// shared constants, beat types and control structs of the bit field buffer engine
package bfb_pkg;

    localparam int BUF_BYTES = 64;
    localparam int BYTE_BITS = 8;
    localparam int BUF_BITS  = BUF_BYTES * BYTE_BITS;

    localparam int WORD_BITS = 64;
    localparam int WORD_SH   = $clog2(WORD_BITS);
    localparam int WORDS     = (BUF_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam int MODE_W  = 3;
    localparam int OFS_W   = 9;
    localparam int CNT_W   = 10;
    localparam int END_W   = CNT_W + 1;
    localparam int FIELD_MAX = 64;

    localparam logic [MODE_W-1:0] MODE_GET  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ZERO = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ONES = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TEST = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [OFS_W-1:0]  bit_offset;
        logic [CNT_W-1:0]  bit_count;
        logic [63:0]       write_value;
    } req_t;

    typedef struct packed {
        logic [63:0] read_value;
        logic        range_is_zero;
        logic        request_error;
    } rsp_t;

    // per-word controls handed to the word unit
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [WORD_SH-1:0] ofs_lo;
        logic [WORD_SH-1:0] lo;
        logic [WORD_SH-1:0] hi;
        logic               is_first;
    } alu_ctrl_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] new_word;
        logic                 we;
        logic [63:0]          rd_part;
        logic                 any_one;
    } alu_res_t;

endpackage

@@ sv/bfb_ram.sv @@
// generic single write port, single read port ram with registered read
module bfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/bfb_word_alu.sv @@
// masks one buffer word and merges, extracts or tests the field bits in it
module bfb_word_alu
    import bfb_pkg::*;
(
    input  alu_ctrl_t            ctrl,
    input  logic [WORD_BITS-1:0] word_in,
    input  logic [63:0]          write_value,
    output alu_res_t             res
);

    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] masked;
    logic [WORD_BITS-1:0] ins;
    logic [WORD_SH:0]     shamt;

    always_comb
    begin
        mask   = ({WORD_BITS{1'b1}} << ctrl.lo)
               & ({WORD_BITS{1'b1}} >> (WORD_SH'(WORD_BITS - 1) - ctrl.hi));
        masked = word_in & mask;
        // distance from the field start to bit 0 of the following word
        shamt  = (WORD_SH+1)'(WORD_BITS) - {1'b0, ctrl.ofs_lo};

        if (ctrl.is_first)
        begin
            res.rd_part = masked >> ctrl.ofs_lo;
            ins         = write_value << ctrl.ofs_lo;
        end
        else
        begin
            res.rd_part = masked << shamt;
            ins         = write_value >> shamt;
        end

        res.any_one = |masked;

        unique case (ctrl.mode)
            MODE_PUT:
            begin
                res.new_word = (word_in & ~mask) | (ins & mask);
                res.we       = 1'b1;
            end
            MODE_ZERO:
            begin
                res.new_word = word_in & ~mask;
                res.we       = 1'b1;
            end
            MODE_ONES:
            begin
                res.new_word = word_in | mask;
                res.we       = 1'b1;
            end
            default:
            begin
                res.new_word = word_in;
                res.we       = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/bit_field_buffer_engine.sv @@
// top level: request sequencer over the word ram of the bit field buffer
//
//  channel | valid     | stall     | beat
//  --------+-----------+-----------+--------------------------------------
//  request | in_valid  | in_stall  | in_data  (mode, offset, count, value)
//  result  | out_valid | out_stall | out_data (read value, zero, error)
//
// a request walks the 64-bit ram words it covers, one word per cycle after a
// read lead-in state: get and put touch one or two words, zero, ones and test
// up to eight. refused or empty requests skip the walk and go straight to the
// finish state. reset clears the per-word valid bits, so the buffer reads as
// zero at once with no clearing pass. a new request is taken while a result
// still waits under out_stall; only the final load waits for the slot.
module bit_field_buffer_engine
    import bfb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_stall,
    output rsp_t out_data
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_MOD, S_FINISH} state_t;

    state_t               state_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [WORD_SH-1:0]   ofs_lo_reg;
    logic [WORD_SH-1:0]   hi_lo_reg;
    logic [WORD_AW-1:0]   first_reg;
    logic [WORD_AW-1:0]   last_reg;
    logic [WORD_AW-1:0]   cur_reg;
    logic [63:0]          wval_reg;
    logic [63:0]          acc_rd_reg;
    logic                 zero_reg;
    logic                 err_reg;
    logic                 rvalid_reg;
    logic [WORDS-1:0]     wvalid_reg;
    logic                 out_valid_reg;
    rsp_t                 out_reg;

    logic [END_W-1:0]     end_bit;
    logic [END_W-1:0]     last_bit;
    logic                 req_err;
    logic                 mode_ok;

    logic                 ram_re;
    logic [WORD_AW-1:0]   ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] word_data;
    alu_ctrl_t            actrl;
    alu_res_t             ares;
    logic                 in_take;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        end_bit  = END_W'(in_data.bit_offset) + END_W'(in_data.bit_count);
        last_bit = end_bit - END_W'(1);
        mode_ok  = (in_data.mode == MODE_GET) || (in_data.mode == MODE_PUT)
                || (in_data.mode == MODE_ZERO) || (in_data.mode == MODE_ONES)
                || (in_data.mode == MODE_TEST);
        req_err  = !mode_ok || (end_bit > END_W'(BUF_BITS))
                || (((in_data.mode == MODE_GET) || (in_data.mode == MODE_PUT))
                    && (in_data.bit_count > CNT_W'(FIELD_MAX)));
    end

    // words never written read as zero
    assign word_data = ram_rdata & {WORD_BITS{rvalid_reg}};

    always_comb
    begin
        actrl.mode     = mode_reg;
        actrl.ofs_lo   = ofs_lo_reg;
        actrl.is_first = (cur_reg == first_reg);
        actrl.lo       = actrl.is_first ? ofs_lo_reg : '0;
        actrl.hi       = (cur_reg == last_reg) ? hi_lo_reg : WORD_SH'(WORD_BITS - 1);
    end

    bfb_word_alu u_alu (
        .ctrl        (actrl),
        .word_in     (word_data),
        .write_value (wval_reg),
        .res         (ares)
    );

    // read of the next word overlaps the write-back of the current one
    always_comb
    begin
        unique case (state_reg)
            S_READ:
            begin
                ram_re    = 1'b1;
                ram_raddr = cur_reg;
            end
            S_MOD:
            begin
                ram_re    = (cur_reg != last_reg);
                ram_raddr = cur_reg + WORD_AW'(1);
            end
            default:
            begin
                ram_re    = 1'b0;
                ram_raddr = cur_reg;
            end
        endcase
    end

    bfb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_ram (
        .clk   (clk),
        .we    ((state_reg == S_MOD) && ares.we),
        .waddr (cur_reg),
        .wdata (ares.new_word),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= '0;
            ofs_lo_reg    <= '0;
            hi_lo_reg     <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            cur_reg       <= '0;
            wval_reg      <= '0;
            acc_rd_reg    <= '0;
            zero_reg      <= 1'b0;
            err_reg       <= 1'b0;
            rvalid_reg    <= 1'b0;
            wvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            // in the finish state the load below decides the slot
            if (out_valid_reg && !out_stall && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            if (ram_re)
            begin
                rvalid_reg <= wvalid_reg[ram_raddr];
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        mode_reg   <= in_data.mode;
                        ofs_lo_reg <= in_data.bit_offset[WORD_SH-1:0];
                        hi_lo_reg  <= last_bit[WORD_SH-1:0];
                        first_reg  <= WORD_AW'(in_data.bit_offset >> WORD_SH);
                        cur_reg    <= WORD_AW'(in_data.bit_offset >> WORD_SH);
                        last_reg   <= WORD_AW'(last_bit >> WORD_SH);
                        wval_reg   <= in_data.write_value;
                        acc_rd_reg <= '0;
                        zero_reg   <= 1'b1;
                        err_reg    <= req_err;
                        if (req_err || (in_data.bit_count == '0))
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_MOD;
                end
                S_MOD:
                begin
                    if (mode_reg == MODE_GET)
                    begin
                        acc_rd_reg <= acc_rd_reg | ares.rd_part;
                    end
                    if (ares.any_one)
                    begin
                        zero_reg <= 1'b0;
                    end
                    if (ares.we)
                    begin
                        wvalid_reg[cur_reg] <= 1'b1;
                    end
                    if (cur_reg == last_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        cur_reg <= cur_reg + WORD_AW'(1);
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg         <= 1'b1;
                        out_reg.read_value    <= acc_rd_reg;
                        out_reg.range_is_zero <= zero_reg && !err_reg
                                                 && (mode_reg == MODE_TEST);
                        out_reg.request_error <= err_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ verif/field_buffer_checker.sv @@
`timescale 1ns / 1ps
// checker for the bit field buffer engine: shadow buffer, expected results, beat compare
module field_buffer_checker
    import bfb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_stall,
    input  req_t in_data,
    input  logic out_valid,
    input  logic out_stall,
    input  rsp_t out_data,
    output int   failures,
    output int   pending
);

    // bit n of the vector is bit offset n of the buffer
    logic [BUF_BITS-1:0] shadow_bits;
    rsp_t                expected_results[$];
    int                  fail_count;

    function automatic rsp_t apply_request(input req_t r);
        rsp_t res;
        int   last;
        int   ofs;
        int   cnt;
        bit   refused;
        res = '0;
        ofs = int'(r.bit_offset);
        cnt = int'(r.bit_count);
        last = ofs + cnt;
        refused = (r.mode > MODE_TEST) || (last > BUF_BITS) ||
                  ((r.mode == MODE_GET || r.mode == MODE_PUT) && cnt > FIELD_MAX);
        if (refused)
        begin
            res.request_error = 1'b1;
            return res;
        end
        case (r.mode)
            MODE_GET:
                for (int i = 0; i < cnt; i++)
                    res.read_value[i] = shadow_bits[ofs + i];
            MODE_PUT:
                for (int i = 0; i < cnt; i++)
                    shadow_bits[ofs + i] = r.write_value[i];
            MODE_ZERO:
                for (int i = 0; i < cnt; i++)
                    shadow_bits[ofs + i] = 1'b0;
            MODE_ONES:
                for (int i = 0; i < cnt; i++)
                    shadow_bits[ofs + i] = 1'b1;
            default:
            begin
                res.range_is_zero = 1'b1;
                for (int i = 0; i < cnt; i++)
                    if (shadow_bits[ofs + i])
                        res.range_is_zero = 1'b0;
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            shadow_bits = '0;
            expected_results.delete();
            fail_count = 0;
            failures <= 0;
            pending <= 0;
        end
        else
        begin
            // results leave before the request of this beat is predicted
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected beat: value %h zero %b err %b",
                                 $realtime, out_data.read_value,
                                 out_data.range_is_zero, out_data.request_error);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.read_value !== want.read_value ||
                        out_data.range_is_zero !== want.range_is_zero ||
                        out_data.request_error !== want.request_error)
                    begin
                        if (fail_count < 10)
                            $display("%0t: expected %h/%b/%b, got %h/%b/%b",
                                     $realtime, want.read_value, want.range_is_zero,
                                     want.request_error, out_data.read_value,
                                     out_data.range_is_zero, out_data.request_error);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(apply_request(in_data));
            failures <= fail_count;
            pending <= expected_results.size();
        end
    end

endmodule

@@ verif/tb_bit_field_buffer_engine.sv @@
`timescale 1ns / 1ps
// stimulus and verdict for the bit field buffer engine
module tb_bit_field_buffer_engine;
    import bfb_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    req_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    rsp_t out_data;

    int failures;
    int pending;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    always #5 clk = ~clk;

    bit_field_buffer_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    field_buffer_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .failures  (failures),
        .pending   (pending)
    );

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    function automatic req_t make_req(input logic [MODE_W-1:0] mode, input int ofs,
                                      input int cnt, input logic [63:0] value);
        req_t r;
        r.mode = mode;
        r.bit_offset = OFS_W'(ofs);
        r.bit_count = CNT_W'(cnt);
        r.write_value = value;
        return r;
    endfunction

    function automatic req_t random_req();
        req_t r;
        int   pick;
        int   cnt;
        int   kind;
        pick = $urandom_range(99);
        r.write_value = {$urandom, $urandom};
        if ($urandom_range(7) == 0)
            r.write_value = '1;
        else if ($urandom_range(7) == 0)
            r.write_value = '0;
        if (pick < 4)
        begin
            // unused modes
            r.mode = MODE_W'($urandom_range(MODE_TEST + 1, 7));
            r.bit_offset = OFS_W'($urandom);
            r.bit_count = CNT_W'($urandom);
        end
        else if (pick < 12)
        begin
            // unconstrained ranges, mostly refused
            r.mode = MODE_W'($urandom_range(MODE_TEST));
            r.bit_offset = OFS_W'($urandom);
            r.bit_count = CNT_W'($urandom);
        end
        else
        begin
            kind = $urandom_range(9);
            if (kind < 3)
                r.mode = MODE_GET;
            else if (kind < 6)
                r.mode = MODE_PUT;
            else if (kind == 6)
                r.mode = MODE_ZERO;
            else if (kind == 7)
                r.mode = MODE_ONES;
            else
                r.mode = MODE_TEST;
            if (r.mode == MODE_GET || r.mode == MODE_PUT || $urandom_range(1) == 0)
                cnt = $urandom_range(FIELD_MAX);
            else
                cnt = $urandom_range(BUF_BITS);
            r.bit_count = CNT_W'(cnt);
            r.bit_offset = OFS_W'($urandom_range((cnt == 0) ? BUF_BITS - 1 : BUF_BITS - cnt));
        end
        return r;
    endfunction

    // holds the beat until accepted; valid stays high into the next beat
    task automatic send_req(input req_t r);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic run_random(input int n);
        for (int k = 0; k < n; k++)
            send_req(random_req());
    endtask

    initial
    begin
        logic [63:0] pattern;
        pattern = {$urandom, $urandom};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, empty ranges, refusals
        send_req(make_req(MODE_GET,  0,   64,  '0));
        send_req(make_req(MODE_TEST, 0,   512, '0));
        send_req(make_req(MODE_PUT,  0,   64,  '1));
        send_req(make_req(MODE_PUT,  448, 64,  pattern));
        send_req(make_req(MODE_GET,  448, 64,  '0));
        send_req(make_req(MODE_PUT,  3,   61,  ~pattern));
        send_req(make_req(MODE_GET,  0,   64,  '0));
        send_req(make_req(MODE_GET,  500, 12,  '0));
        send_req(make_req(MODE_GET,  0,   0,   '0));
        send_req(make_req(MODE_PUT,  100, 0,   '1));
        send_req(make_req(MODE_ZERO, 0,   0,   '0));
        send_req(make_req(MODE_ONES, 7,   0,   '0));
        send_req(make_req(MODE_TEST, 511, 0,   '0));
        send_req(make_req(MODE_ONES, 0,   512, '0));
        send_req(make_req(MODE_TEST, 0,   512, '0));
        send_req(make_req(MODE_ZERO, 0,   512, '0));
        send_req(make_req(MODE_TEST, 0,   512, '0));
        send_req(make_req(MODE_GET,  0,   65,  '0));
        send_req(make_req(MODE_PUT,  10,  65,  '1));
        send_req(make_req(MODE_ONES, 511, 1,   '0));
        send_req(make_req(MODE_GET,  511, 2,   '0));
        send_req(make_req(MODE_TEST, 511, 1023, '0));
        send_req(make_req(3'd5,      0,   1,   '0));
        send_req(make_req(3'd6,      0,   1,   '0));
        send_req(make_req(3'd7,      511, 1,   '1));

        // sender idle and receiver stall phases
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        run_random(150);
        sender_idle_pct = 49;
        receiver_stall_pct = 0;
        run_random(150);
        sender_idle_pct = 0;
        receiver_stall_pct = 49;
        run_random(150);
        sender_idle_pct = 12;
        receiver_stall_pct = 12;
        run_random(150);
        // mixed stretches
        for (int s = 0; s < 8; s++)
        begin
            sender_idle_pct = $urandom_range(2) * 25;
            receiver_stall_pct = $urandom_range(2) * 25;
            run_random(25);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("tb_bit_field_buffer_engine: PASS");
        else
            $display("tb_bit_field_buffer_engine: FAIL");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("tb_bit_field_buffer_engine: FAIL");
        $finish;
    end

endmodule
